// ===== hdl/pbr_pkg.sv =====
// Shared types and constants for the progress-bar rectangle generator.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package pbr_pkg;

	// Field widths
	localparam int COORD_W = 8;
	localparam int LEVEL_W = 16;
	localparam int COLOR_W = 16;
	localparam int OP_W    = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Serial arithmetic: level (16b) x size (8b) -> 24b product, then divide by full scale
	localparam int PROD_W      = LEVEL_W + COORD_W;
	localparam int MUL_STEPS   = COORD_W;
	localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
	localparam int DIV_STEPS   = PROD_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	// Op codes
	localparam logic [OP_W-1:0] OP_SET_VALUE = 2'd0;
	localparam logic [OP_W-1:0] OP_SHOW      = 2'd1;
	localparam logic [OP_W-1:0] OP_REFRESH   = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BAR_WIDTH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BAR_HEIGHT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VERTICAL     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BORDER_COLOR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE   = 3'd7;

	localparam logic [LEVEL_W-1:0] FULL_SCALE_RESET = 16'd100;
	localparam logic [COLOR_W-1:0] BACKGROUND_COLOR = 16'h0000;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [LEVEL_W-1:0] level;
	} cmd_t;

	typedef struct packed {
		logic [COORD_W-1:0] rect_x0;
		logic [COORD_W-1:0] rect_y0;
		logic [COORD_W-1:0] rect_x1;
		logic [COORD_W-1:0] rect_y1;
		logic [COLOR_W-1:0] rect_color;
		logic               last;
	} rect_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BORDER,
		ST_CLEAR,
		ST_MUL,
		ST_DIV,
		ST_FILL
	} state_t;

endpackage

// ===== hdl/pbr_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle (LSB first).
// Depends on pbr_pkg.
module pbr_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pbr_pkg::LEVEL_W-1:0]   mcand,
	input  logic [pbr_pkg::COORD_W-1:0]   mplr,
	output logic                          done,
	output logic [pbr_pkg::PROD_W-1:0]    product
);

	logic                            busy_q;
	logic                            done_q;
	logic [pbr_pkg::MUL_CNT_W-1:0]   cnt_q;
	logic [pbr_pkg::PROD_W-1:0]      acc_q;
	logic [pbr_pkg::PROD_W-1:0]      mc_q;
	logic [pbr_pkg::COORD_W-1:0]     mp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pbr_pkg::MUL_CNT_W'(pbr_pkg::MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q  <= pbr_pkg::PROD_W'(mcand);
			mp_q  <= mplr;
		end else if (busy_q) begin
			if (mp_q[0])
				acc_q <= acc_q + mc_q;
			mc_q <= {mc_q[pbr_pkg::PROD_W-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[pbr_pkg::COORD_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ===== hdl/pbr_div.sv =====
// Restoring divider, one quotient bit per cycle; keeps only the low byte of the quotient.
// Depends on pbr_pkg.
module pbr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pbr_pkg::PROD_W-1:0]    dividend,
	input  logic [pbr_pkg::LEVEL_W-1:0]   divisor,
	output logic                          done,
	output logic [pbr_pkg::COORD_W-1:0]   quot
);

	logic                            busy_q;
	logic                            done_q;
	logic [pbr_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [pbr_pkg::PROD_W-1:0]      dvd_q;
	logic [pbr_pkg::LEVEL_W-1:0]     dsr_q;
	logic [pbr_pkg::LEVEL_W-1:0]     rem_q;
	logic [pbr_pkg::COORD_W-1:0]     quo_q;

	logic [pbr_pkg::LEVEL_W:0]       trial;
	logic [pbr_pkg::LEVEL_W:0]       diff;
	logic                            ge;

	// remainder stays below divisor, so trial fits in 17 bits
	always_comb begin
		trial = {rem_q, dvd_q[pbr_pkg::PROD_W-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = trial >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pbr_pkg::DIV_CNT_W'(pbr_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[pbr_pkg::PROD_W-2:0], 1'b0};
			rem_q <= ge ? diff[pbr_pkg::LEVEL_W-1:0] : trial[pbr_pkg::LEVEL_W-1:0];
			quo_q <= {quo_q[pbr_pkg::COORD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ===== hdl/progress_bar_rectangle_generator_core.sv =====
// Progress-bar rectangle generator: top level with control sequencer and output register.
// Depends on pbr_pkg, pbr_mul, pbr_div.
//
// Takes set-value / show / refresh command words and produces fill-rectangle words for a
// 2D fill engine. Set-value and show leave the sequencer idle. A refresh with a redraw pending
// sends the border and inner-clear words (if a show came before), then runs the fill
// length level * size / full_scale through a bit-serial multiplier and a bit-serial
// restoring divider, and sends the fill or clear word, marked last.
// A refresh with nothing pending leaves the sequencer idle and gives no word.
// Commands are taken only while the sequencer is idle; a word left waiting in the
// output register does not hold off the next command.
// Configuration writes are always taken (cfg_ready is high) and must only come while idle.
module progress_bar_rectangle_generator_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// command channel
	input  logic                               cmd_valid,
	output logic                               cmd_ready,
	input  pbr_pkg::cmd_t                      cmd,
	// rectangle channel
	output logic                               rect_valid,
	input  logic                               rect_ready,
	output pbr_pkg::rect_t                     rect,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pbr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pbr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// config registers
	logic [pbr_pkg::COORD_W-1:0] origin_x_q, origin_y_q, bar_width_q, bar_height_q;
	logic                        vertical_q;
	logic [pbr_pkg::COLOR_W-1:0] border_color_q, fill_color_q;
	logic [pbr_pkg::LEVEL_W-1:0] full_scale_q;

	// bar state
	logic [pbr_pkg::LEVEL_W-1:0] current_level_q;
	logic                        grew_q, redraw_q, border_q;

	pbr_pkg::state_t state_q, state_d;

	// output register
	logic           out_valid_q;
	pbr_pkg::rect_t out_q;

	// sequencer outputs
	logic           emit;
	pbr_pkg::rect_t rect_d;
	logic           mul_start, div_start;

	logic cmd_acc, refresh_go, slot_free;

	logic                        mul_done, div_done;
	logic [pbr_pkg::PROD_W-1:0]  product;
	logic [pbr_pkg::COORD_W-1:0] quot;

	// fill geometry
	logic [pbr_pkg::COORD_W-1:0] size, len;
	logic                        full;
	pbr_pkg::rect_t              fill_rect;

	assign cfg_ready = 1'b1;
	assign cmd_ready = (state_q == pbr_pkg::ST_IDLE);
	assign cmd_acc   = cmd_valid && cmd_ready;
	assign refresh_go = cmd_acc && (cmd.op == pbr_pkg::OP_REFRESH) && redraw_q;
	assign slot_free = !out_valid_q || rect_ready;

	assign size = vertical_q ? bar_height_q : bar_width_q;

	//------------------------------------------------------------------
	// Serial arithmetic
	//------------------------------------------------------------------
	pbr_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (current_level_q),
		.mplr    (size),
		.done    (mul_done),
		.product (product)
	);

	pbr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (full_scale_q),
		.done     (div_done),
		.quot     (quot)
	);

	//------------------------------------------------------------------
	// Fill / clear rectangle; coordinates wrap at 8 bits
	//------------------------------------------------------------------
	always_comb begin
		len  = (full_scale_q == '0) ? '0 : quot;
		// zero full scale also counts as full
		full = ({1'b0, current_level_q} + 17'd1) >= {1'b0, full_scale_q};

		fill_rect.rect_x0    = origin_x_q + 8'd1;
		fill_rect.rect_y0    = origin_y_q + 8'd1;
		fill_rect.rect_x1    = origin_x_q + bar_width_q - 8'd1;
		fill_rect.rect_y1    = origin_y_q + bar_height_q - 8'd1;
		fill_rect.rect_color = pbr_pkg::BACKGROUND_COLOR;
		fill_rect.last       = 1'b1;

		if (vertical_q) begin
			if (grew_q) begin
				if (!full)
					fill_rect.rect_y0 = origin_y_q + bar_height_q - len;
				fill_rect.rect_color = fill_color_q;
			end else begin
				fill_rect.rect_y1 = origin_y_q + bar_height_q - len - 8'd1;
			end
		end else begin
			if (grew_q) begin
				if (!full)
					fill_rect.rect_x1 = origin_x_q + len - 8'd1;
				fill_rect.rect_color = fill_color_q;
			end else begin
				fill_rect.rect_x0 = origin_x_q + len + 8'd1;
			end
		end
	end

	//------------------------------------------------------------------
	// Sequencer: next state
	//------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pbr_pkg::ST_IDLE: begin
				if (refresh_go)
					state_d = border_q ? pbr_pkg::ST_BORDER : pbr_pkg::ST_MUL;
			end
			pbr_pkg::ST_BORDER: begin
				if (slot_free)
					state_d = pbr_pkg::ST_CLEAR;
			end
			pbr_pkg::ST_CLEAR: begin
				if (slot_free)
					state_d = pbr_pkg::ST_MUL;
			end
			pbr_pkg::ST_MUL: begin
				if (mul_done)
					state_d = pbr_pkg::ST_DIV;
			end
			pbr_pkg::ST_DIV: begin
				if (div_done)
					state_d = pbr_pkg::ST_FILL;
			end
			pbr_pkg::ST_FILL: begin
				if (slot_free)
					state_d = pbr_pkg::ST_IDLE;
			end
			default: state_d = pbr_pkg::ST_IDLE;
		endcase
	end

	//------------------------------------------------------------------
	// Sequencer: outputs
	//------------------------------------------------------------------
	always_comb begin
		emit      = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		rect_d    = fill_rect;
		unique case (state_q)
			pbr_pkg::ST_IDLE: begin
				mul_start = refresh_go && !border_q;
			end
			pbr_pkg::ST_BORDER: begin
				emit              = slot_free;
				rect_d.rect_x0    = origin_x_q;
				rect_d.rect_y0    = origin_y_q;
				rect_d.rect_x1    = origin_x_q + bar_width_q;
				rect_d.rect_y1    = origin_y_q + bar_height_q;
				rect_d.rect_color = border_color_q;
				rect_d.last       = 1'b0;
			end
			pbr_pkg::ST_CLEAR: begin
				emit              = slot_free;
				mul_start         = slot_free;
				rect_d.rect_x0    = origin_x_q + 8'd1;
				rect_d.rect_y0    = origin_y_q + 8'd1;
				rect_d.rect_x1    = origin_x_q + bar_width_q - 8'd1;
				rect_d.rect_y1    = origin_y_q + bar_height_q - 8'd1;
				rect_d.rect_color = pbr_pkg::BACKGROUND_COLOR;
				rect_d.last       = 1'b0;
			end
			pbr_pkg::ST_MUL: begin
				div_start = mul_done;
			end
			pbr_pkg::ST_DIV: begin
			end
			pbr_pkg::ST_FILL: begin
				emit = slot_free;
			end
			default: begin
			end
		endcase
	end

	//------------------------------------------------------------------
	// Registers
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			bar_width_q    <= '0;
			bar_height_q   <= '0;
			vertical_q     <= 1'b0;
			border_color_q <= '0;
			fill_color_q   <= '0;
			full_scale_q   <= pbr_pkg::FULL_SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pbr_pkg::REG_ORIGIN_X:     origin_x_q     <= cfg_data[pbr_pkg::COORD_W-1:0];
				pbr_pkg::REG_ORIGIN_Y:     origin_y_q     <= cfg_data[pbr_pkg::COORD_W-1:0];
				pbr_pkg::REG_BAR_WIDTH:    bar_width_q    <= cfg_data[pbr_pkg::COORD_W-1:0];
				pbr_pkg::REG_BAR_HEIGHT:   bar_height_q   <= cfg_data[pbr_pkg::COORD_W-1:0];
				pbr_pkg::REG_VERTICAL:     vertical_q     <= cfg_data[0];
				pbr_pkg::REG_BORDER_COLOR: border_color_q <= cfg_data;
				pbr_pkg::REG_FILL_COLOR:   fill_color_q   <= cfg_data;
				pbr_pkg::REG_FULL_SCALE:   full_scale_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// bar state flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_level_q <= '0;
			grew_q          <= 1'b1;
			redraw_q        <= 1'b0;
			border_q        <= 1'b0;
		end else begin
			if (cmd_acc && cmd.op == pbr_pkg::OP_SET_VALUE) begin
				redraw_q        <= 1'b1;
				current_level_q <= cmd.level;
				if (cmd.level > current_level_q)
					grew_q <= 1'b1;
			end
			if (cmd_acc && cmd.op == pbr_pkg::OP_SHOW) begin
				redraw_q <= 1'b1;
				border_q <= 1'b1;
			end
			if (refresh_go) begin
				redraw_q <= 1'b0;
				border_q <= 1'b0;
			end
			// grew is consumed by the fill word
			if (state_q == pbr_pkg::ST_FILL && slot_free)
				grew_q <= 1'b0;
		end
	end

	// output register: loads while empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rect_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_q <= rect_d;
	end

	assign rect_valid = out_valid_q;
	assign rect       = out_q;

endmodule

// ===== hdl/pbr_checker.sv =====
// Port-level checks for the progress-bar rectangle generator, bound to the top level.
// Depends on pbr_pkg and progress_bar_rectangle_generator_core.
module pbr_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cmd_valid,
	input logic                               cmd_ready,
	input pbr_pkg::cmd_t                      cmd,
	input logic                               rect_valid,
	input logic                               rect_ready,
	input pbr_pkg::rect_t                     rect
);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rect_valid && !rect_ready |=> rect_valid && $stable(rect))
		else $error("rect word changed while stalled");

	// a set-value or show never yields a word
	a_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd.op != pbr_pkg::OP_REFRESH && !rect_valid
		|=> !rect_valid)
		else $error("word produced by a non-refresh command");

	// set-value and show leave the block ready
	a_stay_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd.op != pbr_pkg::OP_REFRESH |=> cmd_ready)
		else $error("block busy after a one-cycle command");

	// while a non-final word is on the output the refresh is still running
	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rect_valid && !rect.last |-> !cmd_ready)
		else $error("command taken before the refresh finished");

endmodule

bind progress_bar_rectangle_generator_core pbr_checker u_pbr_checker (.*);

// ===== test/pbr_rect_check.sv =====
`timescale 1ns / 1ps
// Rectangle checker for the progress-bar generator: tracks config writes and command words,
// predicts the rectangle words each refresh should produce, and compares them in order.
// Depends on pbr_pkg for the word types, op codes and register indexes.
module pbr_rect_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	input  logic                           cmd_ready,
	input  pbr_pkg::cmd_t                  cmd,
	input  logic                           rect_valid,
	input  logic                           rect_ready,
	input  pbr_pkg::rect_t                 rect,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [pbr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbr_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatch_count,
	output int                             rects_outstanding
);
	import pbr_pkg::*;

	// shadow registers
	logic [COORD_W-1:0] org_x, org_y, frame_w, frame_h;
	logic               vert;
	logic [COLOR_W-1:0] border_rgb, fill_rgb;
	logic [LEVEL_W-1:0] scale;

	// bar state
	logic [LEVEL_W-1:0] bar_level;
	logic               grew, redraw_due, border_due;

	rect_t expected_rects[$];

	function automatic rect_t make_rect(input logic [COORD_W-1:0] x0, y0, x1, y1,
			input logic [COLOR_W-1:0] paint, input logic fin);
		rect_t r;
		r.rect_x0    = x0;
		r.rect_y0    = y0;
		r.rect_x1    = x1;
		r.rect_y1    = y1;
		r.rect_color = paint;
		r.last       = fin;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		rect_t              want;
		logic [31:0]        len;
		logic [COORD_W-1:0] len8, x0, y0, x1, y1;
		logic [COLOR_W-1:0] paint;
		logic               at_full;
		if (!arst_n) begin
			org_x      = '0;
			org_y      = '0;
			frame_w    = '0;
			frame_h    = '0;
			vert       = 1'b0;
			border_rgb = '0;
			fill_rgb   = '0;
			scale      = FULL_SCALE_RESET;
			bar_level  = '0;
			grew       = 1'b1;
			redraw_due = 1'b0;
			border_due = 1'b0;
			expected_rects.delete();
			mismatch_count = 0;
		end else begin
			if (rect_valid && rect_ready) begin
				if (expected_rects.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("rect word with none expected: x0=%0d y0=%0d x1=%0d y1=%0d c=%h l=%0d",
							rect.rect_x0, rect.rect_y0, rect.rect_x1, rect.rect_y1,
							rect.rect_color, rect.last);
				end else begin
					want = expected_rects.pop_front();
					if (rect.rect_x0 !== want.rect_x0 || rect.rect_y0 !== want.rect_y0 ||
							rect.rect_x1 !== want.rect_x1 || rect.rect_y1 !== want.rect_y1 ||
							rect.rect_color !== want.rect_color || rect.last !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"rect mismatch: exp x0=%0d y0=%0d x1=%0d y1=%0d c=%h l=%0d",
								" | got x0=%0d y0=%0d x1=%0d y1=%0d c=%h l=%0d"},
								want.rect_x0, want.rect_y0, want.rect_x1, want.rect_y1,
								want.rect_color, want.last,
								rect.rect_x0, rect.rect_y0, rect.rect_x1, rect.rect_y1,
								rect.rect_color, rect.last);
					end
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ORIGIN_X:     org_x      = cfg_data[COORD_W-1:0];
					REG_ORIGIN_Y:     org_y      = cfg_data[COORD_W-1:0];
					REG_BAR_WIDTH:    frame_w    = cfg_data[COORD_W-1:0];
					REG_BAR_HEIGHT:   frame_h    = cfg_data[COORD_W-1:0];
					REG_VERTICAL:     vert       = cfg_data[0];
					REG_BORDER_COLOR: border_rgb = cfg_data;
					REG_FILL_COLOR:   fill_rgb   = cfg_data;
					REG_FULL_SCALE:   scale      = cfg_data;
				endcase
			end

			if (cmd_valid && cmd_ready) begin
				case (cmd.op)
					OP_SET_VALUE: begin
						redraw_due = 1'b1;
						if (cmd.level > bar_level)
							grew = 1'b1;
						bar_level = cmd.level;
					end
					OP_SHOW: begin
						border_due = 1'b1;
						redraw_due = 1'b1;
					end
					OP_REFRESH: begin
						if (redraw_due) begin
							redraw_due = 1'b0;
							if (border_due) begin
								border_due = 1'b0;
								expected_rects.push_back(make_rect(org_x, org_y,
									org_x + frame_w, org_y + frame_h, border_rgb, 1'b0));
								expected_rects.push_back(make_rect(org_x + 8'd1, org_y + 8'd1,
									org_x + frame_w - 8'd1, org_y + frame_h - 8'd1,
									BACKGROUND_COLOR, 1'b0));
							end
							// zero scale: no length, and the bar reads as full
							len = (scale == '0) ? 32'd0 :
								(32'(bar_level) * 32'(vert ? frame_h : frame_w)) / 32'(scale);
							len8    = len[COORD_W-1:0];
							at_full = (32'(bar_level) + 32'd1) >= 32'(scale);
							x0 = org_x + 8'd1;
							y0 = org_y + 8'd1;
							x1 = org_x + frame_w - 8'd1;
							y1 = org_y + frame_h - 8'd1;
							if (vert) begin
								if (grew) begin
									if (!at_full)
										y0 = org_y + frame_h - len8;
									paint = fill_rgb;
								end else begin
									y1 = org_y + frame_h - len8 - 8'd1;
									paint = BACKGROUND_COLOR;
								end
							end else begin
								if (grew) begin
									if (!at_full)
										x1 = org_x + len8 - 8'd1;
									paint = fill_rgb;
								end else begin
									x0 = org_x + len8 + 8'd1;
									paint = BACKGROUND_COLOR;
								end
							end
							grew = 1'b0;
							expected_rects.push_back(make_rect(x0, y0, x1, y1, paint, 1'b1));
						end
					end
					default: ;
				endcase
			end
		end
		rects_outstanding = expected_rects.size();
	end

endmodule

// ===== test/tb_progress_bar_rectangle_generator_core.sv =====
`timescale 1ns / 1ps
// Testbench top for progress_bar_rectangle_generator_core: clock, reset, command and config
// stimulus, rectangle sink with stalls, watchdog and verdict. Checking is done in pbr_rect_check.
// Depends on pbr_pkg, pbr_rect_check and the core RTL.
module tb_progress_bar_rectangle_generator_core;
	import pbr_pkg::*;

	// op code the block must ignore
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int HOLD_CYCLES   = 400;  // long receiver hold-off, fills the block
	localparam int DRAIN_CYCLES  = 60;   // lets a refresh still in flight finish
	localparam int STALL_LIMIT   = 5000; // cycles with no word moving on any channel
	localparam int PHASE_ITEMS   = 57;

	typedef struct packed {
		logic [COORD_W-1:0] org_x;
		logic [COORD_W-1:0] org_y;
		logic [COORD_W-1:0] span_w;
		logic [COORD_W-1:0] span_h;
		logic               vert;
		logic [COLOR_W-1:0] border_rgb;
		logic [COLOR_W-1:0] fill_rgb;
		logic [LEVEL_W-1:0] scale;
	} bar_cfg_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cmd_valid;
	logic                  cmd_ready;
	cmd_t                  cmd;
	logic                  rect_valid;
	logic                  rect_ready;
	rect_t                 rect;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatch_count;
	int rects_outstanding;
	int idle_cycles = 0;
	int hold_req_cnt = 0;   // bumped by stimulus, served by the rect sink
	int burst_left = 0;
	bit gappy = 1'b0;

	progress_bar_rectangle_generator_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.rect_valid (rect_valid),
		.rect_ready (rect_ready),
		.rect       (rect),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	pbr_rect_check u_rect_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd_valid         (cmd_valid),
		.cmd_ready         (cmd_ready),
		.cmd               (cmd),
		.rect_valid        (rect_valid),
		.rect_ready        (rect_ready),
		.rect              (rect),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.mismatch_count    (mismatch_count),
		.rects_outstanding (rects_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: any word moving on any channel restarts the count.
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rect_valid && rect_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_progress_bar_rectangle_generator_core: FAIL");
				$finish;
			end
		end
	end

	// Rect sink: stretches of random length, each with its own ready pattern.
	// A hold request from the stimulus side drops ready for HOLD_CYCLES straight.
	initial begin : rect_sink
		int mode;
		int span;
		int holds_done;
		rect_ready = 1'b0;
		holds_done = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 150);
			for (int i = 0; i < span; i++) begin
				@(negedge clk);
				if (hold_req_cnt != holds_done) begin
					holds_done++;
					rect_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
				end
				case (mode)
					0:       rect_ready <= 1'b1;                         // no stalls
					1:       rect_ready <= 1'($urandom_range(0, 1));
					2:       rect_ready <= ($urandom_range(0, 3) == 0);  // mostly stalled
					default: rect_ready <= ((i % 5) < 2);                // fixed 2-of-5
				endcase
			end
		end
	end

	// Sends one command word; call and return at a falling edge. valid stays up
	// inside a burst, so back-to-back words keep it high with one update per edge while cmd_ready holds.
	task automatic send_word(input logic [OP_W-1:0] op, input logic [LEVEL_W-1:0] level);
		cmd_valid <= 1'b1;
		cmd       <= '{op: op, level: level};
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		@(negedge clk);
		if (gappy) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				cmd_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				burst_left = $urandom_range(0, 15);
			end
		end
	endtask

	// One config word; cfg_valid is handled by the caller.
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Writes every register back to back; only called with the block idle.
	task automatic program_bar(input bar_cfg_t s);
		cfg_valid <= 1'b1;
		put_reg(REG_ORIGIN_X,     CFG_DATA_W'(s.org_x));
		put_reg(REG_ORIGIN_Y,     CFG_DATA_W'(s.org_y));
		put_reg(REG_BAR_WIDTH,    CFG_DATA_W'(s.span_w));
		put_reg(REG_BAR_HEIGHT,   CFG_DATA_W'(s.span_h));
		put_reg(REG_VERTICAL,     CFG_DATA_W'(s.vert));
		put_reg(REG_BORDER_COLOR, s.border_rgb);
		put_reg(REG_FILL_COLOR,   s.fill_rgb);
		put_reg(REG_FULL_SCALE,   s.scale);
		cfg_valid <= 1'b0;
	endtask

	// Sender pause: drop valid, wait for every predicted word, then let an
	// empty refresh still in flight finish before anything else happens.
	task automatic settle();
		cmd_valid <= 1'b0;
		while (rects_outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		burst_left = 0;
	endtask

	// Levels cluster around the full-scale point, plus both ends and raw noise.
	function automatic logic [LEVEL_W-1:0] pick_level(input logic [LEVEL_W-1:0] scale);
		case ($urandom_range(0, 5))
			0:       return LEVEL_W'($urandom_range(0, scale));
			1:       return scale + LEVEL_W'($urandom_range(0, 2)) - 16'd1;
			2:       return '0;
			3:       return '1;
			default: return LEVEL_W'($urandom);
		endcase
	endfunction

	// First three phases pin the extremes, the rest are random frames.
	function automatic bar_cfg_t pick_settings(input int ph);
		bar_cfg_t s;
		s.org_x      = COORD_W'($urandom);
		s.org_y      = COORD_W'($urandom);
		s.span_w     = COORD_W'($urandom);
		s.span_h     = COORD_W'($urandom);
		s.vert       = 1'($urandom);
		s.border_rgb = COLOR_W'($urandom);
		s.fill_rgb   = COLOR_W'($urandom);
		case ($urandom_range(0, 3))
			0:       s.scale = LEVEL_W'($urandom_range(1, 300));
			1:       s.scale = LEVEL_W'($urandom_range(1, 10));
			default: s.scale = LEVEL_W'($urandom);
		endcase
		case (ph)
			0: begin
				// everything at the top: all coordinate sums wrap, zero scale
				s = '{org_x: '1, org_y: '1, span_w: '1, span_h: '1, vert: 1'b0,
					border_rgb: '1, fill_rgb: '1, scale: '0};
			end
			1: begin
				s.org_x  = '0;
				s.org_y  = '0;
				s.span_w = '1;
				s.span_h = '1;
				s.vert   = 1'b1;
				s.scale  = '1;
			end
			2: s.scale = 16'd1;
			default: ;
		endcase
		return s;
	endfunction

	// One random command sequence; n counts the words that do real work.
	task automatic send_sequence(input logic [LEVEL_W-1:0] scale, output int n);
		case ($urandom_range(0, 10))
			0, 1, 2, 3, 4: begin
				send_word(OP_SET_VALUE, pick_level(scale));
				send_word(OP_REFRESH, LEVEL_W'($urandom));
				n = 2;
			end
			5, 6: begin
				send_word(OP_SHOW, LEVEL_W'($urandom));
				send_word(OP_SET_VALUE, pick_level(scale));
				send_word(OP_REFRESH, LEVEL_W'($urandom));
				n = 3;
			end
			7: begin
				send_word(OP_SHOW, LEVEL_W'($urandom));
				send_word(OP_REFRESH, LEVEL_W'($urandom));
				n = 2;
			end
			8: begin
				send_word(OP_SET_VALUE, pick_level(scale));
				send_word(OP_SET_VALUE, pick_level(scale));
				send_word(OP_REFRESH, LEVEL_W'($urandom));
				n = 3;
			end
			9: begin
				// noise: unused op or a refresh that may find nothing to draw
				if ($urandom_range(0, 1))
					send_word(OP_UNUSED, LEVEL_W'($urandom));
				else
					send_word(OP_REFRESH, LEVEL_W'($urandom));
				n = 0;
			end
			default: begin
				// broken sequence: a set with no refresh behind it
				send_word(OP_SET_VALUE, pick_level(scale));
				n = 1;
			end
		endcase
	endtask

	initial begin : stimulus
		bar_cfg_t settings;
		int       sent;
		int       n;
		bit       paused;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, reset config (zero frame, every inner corner wraps).
		send_word(OP_REFRESH, 16'h0000);     // nothing pending: no words
		send_word(OP_UNUSED, 16'hFFFF);      // ignored op
		send_word(OP_SET_VALUE, 16'd0);      // grew flag is set out of reset
		send_word(OP_REFRESH, 16'hFFFF);
		settle();

		// Directed, horizontal frame.
		program_bar('{org_x: 8'd10, org_y: 8'd20, span_w: 8'd100, span_h: 8'd40, vert: 1'b0,
			border_rgb: 16'hFFFF, fill_rgb: 16'h07E0, scale: 16'd100});
		send_word(OP_SHOW, 16'd0);           // border plus inner clear
		send_word(OP_SET_VALUE, 16'd50);
		send_word(OP_REFRESH, 16'd0);
		send_word(OP_SET_VALUE, 16'd20);     // fall: clear past the level
		send_word(OP_REFRESH, 16'd0);
		send_word(OP_SET_VALUE, 16'd99);     // one below scale counts as full
		send_word(OP_REFRESH, 16'd0);
		send_word(OP_SET_VALUE, 16'hFFFF);   // beyond full scale
		send_word(OP_REFRESH, 16'd0);
		send_word(OP_SET_VALUE, 16'hFFFF);   // same level: takes the fall path
		send_word(OP_REFRESH, 16'd0);
		settle();

		// Directed, vertical frame.
		program_bar('{org_x: 8'd200, org_y: 8'd230, span_w: 8'd80, span_h: 8'd50, vert: 1'b1,
			border_rgb: 16'h001F, fill_rgb: 16'hF800, scale: 16'd100});
		send_word(OP_SHOW, 16'd0);
		send_word(OP_SET_VALUE, 16'd30);
		send_word(OP_REFRESH, 16'd0);
		send_word(OP_SET_VALUE, 16'd10);
		send_word(OP_REFRESH, 16'd0);
		send_word(OP_SET_VALUE, 16'd100);
		send_word(OP_REFRESH, 16'd0);
		settle();

		// Random phases, a fresh config each, block idle at every switch.
		for (int ph = 0; ph < 8; ph++) begin
			settings = pick_settings(ph);
			program_bar(settings);
			gappy = (ph % 2 == 0);
			// long sink hold while words keep coming: output backs up into cmd_ready
			if (ph == 3)
				hold_req_cnt++;
			sent   = 0;
			paused = 1'b0;
			while (sent < PHASE_ITEMS) begin
				if (ph == 5 && sent >= 25 && !paused) begin
					settle();
					paused = 1'b1;
				end
				send_sequence(settings.scale, n);
				sent += n;
			end
			settle();
		end

		if (mismatch_count == 0 && rects_outstanding == 0)
			$display("tb_progress_bar_rectangle_generator_core: PASS");
		else
			$display("tb_progress_bar_rectangle_generator_core: FAIL");
		$finish;
	end

endmodule

// ===== progress_bar_rectangle_generator_core.f =====
hdl/pbr_pkg.sv
hdl/pbr_mul.sv
hdl/pbr_div.sv
hdl/progress_bar_rectangle_generator_core.sv
hdl/pbr_checker.sv
test/pbr_rect_check.sv
test/tb_progress_bar_rectangle_generator_core.sv
